FILE: hdl/brush_stroke_line_stamper_defines.svh
// assertion macros for the brush stroke line stamper checker
// expects clk and rst_n in the scope of each use
`ifndef BRUSH_STROKE_LINE_STAMPER_DEFINES_SVH
`define BRUSH_STROKE_LINE_STAMPER_DEFINES_SVH

// condition implies consequence in the same cycle
`define BSLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define BSLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bsls_pkg.sv
// shared constants, codes and types of the brush stroke line stamper
// no dependencies
package bsls_pkg;

    localparam int BRUSH    = 8;
    localparam int MAX_DIM  = 64;
    localparam int COORD_W  = 6;
    localparam int DIM_W    = 7;
    localparam int SIZE_W   = 5;
    localparam int COLOR_W  = 32;
    localparam int PTR_W    = 12;
    localparam int LOCAL_W  = PTR_W + 1;
    localparam int DELTA_W  = COORD_W + 1;
    localparam int ACT_W    = 2;
    localparam int INDEX_W  = 3;
    localparam int DATA_W   = 32;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    typedef enum logic [ACT_W-1:0] {
        ACT_PRESS   = 2'd0,
        ACT_MOVE    = 2'd1,
        ACT_RELEASE = 2'd2
    } action_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_CANVAS_WIDTH  = 3'd0,
        REG_CANVAS_HEIGHT = 3'd1,
        REG_ORIGIN_X      = 3'd2,
        REG_ORIGIN_Y      = 3'd3,
        REG_PEN_COLOR     = 3'd4,
        REG_ENABLED       = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [PTR_W-1:0]   ox;
        logic [PTR_W-1:0]   oy;
        logic [COLOR_W-1:0] color;
        logic               enabled;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0]        ax;
        logic [COORD_W-1:0]        ay;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [COORD_W-1:0]        steps;
    } cmd_t;

endpackage

FILE: hdl/bsls_if.sv
// valid/ready channels of the brush stroke line stamper: events, rectangles, config
// depends on bsls_pkg
interface bsls_event_if import bsls_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [PTR_W-1:0]   pointer_x;
    logic [PTR_W-1:0]   pointer_y;

    modport source (output valid, action, pointer_x, pointer_y, input ready);
    modport sink   (input valid, action, pointer_x, pointer_y, output ready);
endinterface

interface bsls_rect_if import bsls_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [SIZE_W-1:0]  rect_w;
    logic [SIZE_W-1:0]  rect_h;
    logic [COLOR_W-1:0] color;
    logic               last;

    modport source (output valid, rect_x, rect_y, rect_w, rect_h, color, last, input ready);
    modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, color, last, output ready);
endinterface

interface bsls_cfg_if import bsls_pkg::*;;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/bsls_queue.sv
// command queue between the event front end and the line walker
// depends on bsls_pkg
module bsls_queue
    import bsls_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1))
            wrap_inc = '0;
        else
            wrap_inc = p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: hdl/bsls_front.sv
// event front end: localizes and classifies events, keeps stroke state, issues line commands
// depends on bsls_pkg and bsls_if
module bsls_front
    import bsls_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bsls_event_if.sink   evt,
    input  cfg_t         cfg,
    output logic         push_valid,
    input  logic         push_ready,
    output cmd_t         push_cmd
);

    logic                      s1_valid_reg;
    logic [ACT_W-1:0]          s1_act_reg;
    logic signed [LOCAL_W-1:0] s1_lx_reg, s1_ly_reg;
    logic                      active_reg, active_next;
    logic [COORD_W-1:0]        prev_x_reg, prev_x_next;
    logic [COORD_W-1:0]        prev_y_reg, prev_y_next;

    logic                      evt_take, need_push, s2_done, in_x, in_y;
    logic [COORD_W-1:0]        cx, cy, mag_x, mag_y;
    logic signed [DELTA_W-1:0] dx, dy;

    function automatic logic axis_inside(input logic signed [LOCAL_W-1:0] v,
                                         input logic [DIM_W-1:0] lim);
        axis_inside = !v[LOCAL_W-1] && (v[PTR_W-1:0] < PTR_W'(lim));
    endfunction

    function automatic logic [COORD_W-1:0] axis_clamp(input logic signed [LOCAL_W-1:0] v,
                                                      input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] lim_m1;
        lim_m1 = lim - 1'b1;
        if (v[LOCAL_W-1])
            axis_clamp = '0;
        else if (v[PTR_W-1:0] >= PTR_W'(lim))
            axis_clamp = lim_m1[COORD_W-1:0];
        else
            axis_clamp = v[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] magnitude(input logic signed [DELTA_W-1:0] d);
        logic [DELTA_W-1:0] m;
        m = d[DELTA_W-1] ? DELTA_W'(-d) : DELTA_W'(d);
        magnitude = m[COORD_W-1:0];
    endfunction

    assign evt_take = evt.valid && evt.ready;

    always_comb
    begin
        in_x  = axis_inside(s1_lx_reg, cfg.w);
        in_y  = axis_inside(s1_ly_reg, cfg.h);
        cx    = axis_clamp(s1_lx_reg, cfg.w);
        cy    = axis_clamp(s1_ly_reg, cfg.h);
        dx    = $signed({1'b0, cx}) - $signed({1'b0, prev_x_reg});
        dy    = $signed({1'b0, cy}) - $signed({1'b0, prev_y_reg});
        mag_x = magnitude(dx);
        mag_y = magnitude(dy);

        need_push   = 1'b0;
        active_next = active_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        push_cmd    = '{ax: cx, ay: cy, dx: '0, dy: '0, steps: '0};

        if (cfg.enabled)
        begin
            unique case (s1_act_reg)
                ACT_PRESS:
                begin
                    if (in_x && in_y)
                    begin
                        need_push   = 1'b1;
                        active_next = 1'b1;
                        prev_x_next = cx;
                        prev_y_next = cy;
                    end
                end
                ACT_MOVE:
                begin
                    if (active_reg)
                    begin
                        need_push   = 1'b1;
                        prev_x_next = cx;
                        prev_y_next = cy;
                        push_cmd    = '{ax: prev_x_reg, ay: prev_y_reg, dx: dx, dy: dy,
                                        steps: (mag_x > mag_y) ? mag_x : mag_y};
                    end
                end
                ACT_RELEASE:
                    active_next = 1'b0;
                default:
                    ;
            endcase
        end

        s2_done    = s1_valid_reg && (!need_push || push_ready);
        push_valid = s1_valid_reg && need_push;
        evt.ready  = !s1_valid_reg || s2_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            active_reg   <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
        end
        else
        begin
            if (evt_take)
                s1_valid_reg <= 1'b1;
            else if (s2_done)
                s1_valid_reg <= 1'b0;
            if (s2_done)
            begin
                active_reg <= active_next;
                prev_x_reg <= prev_x_next;
                prev_y_reg <= prev_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            s1_act_reg <= evt.action;
            s1_lx_reg  <= $signed({1'b0, evt.pointer_x}) - $signed({1'b0, cfg.ox});
            s1_ly_reg  <= $signed({1'b0, evt.pointer_y}) - $signed({1'b0, cfg.oy});
        end
    end

endmodule

FILE: hdl/bsls_back.sv
// line walker: steps exact round-half-up dda points and stamps clipped brush rectangles
// depends on bsls_pkg and bsls_if
module bsls_back
    import bsls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  cmd_t        pop_cmd,
    bsls_rect_if.source rect
);

    localparam int REM_W = DELTA_W + 2;
    localparam int POS_W = COORD_W + 2;
    localparam logic signed [POS_W-1:0] HALF_S  = POS_W'(BRUSH / 2);
    localparam logic signed [POS_W-1:0] BRUSH_S = POS_W'(BRUSH);

    typedef struct packed {
        logic [COORD_W-1:0] pos;
        logic [SIZE_W-1:0]  len;
    } span_t;

    logic                      busy_reg, out_valid_reg;
    logic [COORD_W-1:0]        ax_reg, ay_reg, steps_reg, i_reg;
    logic signed [REM_W-1:0]   dx2_reg, dy2_reg, two_s_reg, remx_reg, remy_reg;
    logic signed [DELTA_W-1:0] qx_reg, qy_reg;

    logic                      fire, load, at_last;
    logic signed [POS_W-1:0]   xs, ys;
    logic [COORD_W-1:0]        px, py;
    logic signed [REM_W-1:0]   remx_next, remy_next;
    logic signed [DELTA_W-1:0] qx_next, qy_next;
    span_t                     span_x, span_y;

    function automatic logic [COORD_W-1:0] clamp_hi(input logic [COORD_W-1:0] p,
                                                    input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] lim_m1;
        lim_m1 = lim - 1'b1;
        clamp_hi = ({1'b0, p} >= lim) ? lim_m1[COORD_W-1:0] : p;
    endfunction

    function automatic span_t stamp_axis(input logic [COORD_W-1:0] p,
                                         input logic [DIM_W-1:0] lim);
        logic signed [POS_W-1:0] r, n, l;
        l = $signed({1'b0, lim});
        r = $signed({2'b0, p}) - HALF_S;
        n = BRUSH_S;
        if (r < 0)
        begin
            n = n + r;
            r = '0;
        end
        if (r + n > l)
            n = l - r;
        stamp_axis = '{pos: r[COORD_W-1:0], len: n[SIZE_W-1:0]};
    endfunction

    function automatic logic signed [REM_W+DELTA_W-1:0] dda_step(
        input logic signed [REM_W-1:0]   rem,
        input logic signed [DELTA_W-1:0] q,
        input logic signed [REM_W-1:0]   d2,
        input logic signed [REM_W-1:0]   two_s);
        logic signed [REM_W-1:0]   nr;
        logic signed [DELTA_W-1:0] nq;
        nr = rem + d2;
        nq = q;
        if (nr >= two_s)
        begin
            nr = nr - two_s;
            nq = q + DELTA_W'(1);
        end
        else if (nr < 0)
        begin
            nr = nr + two_s;
            nq = q - DELTA_W'(1);
        end
        dda_step = {nr, nq};
    endfunction

    always_comb
    begin
        fire      = busy_reg && (!out_valid_reg || rect.ready);
        load      = !busy_reg && pop_valid;
        pop_ready = !busy_reg;
        at_last   = i_reg == steps_reg;

        xs     = $signed({2'b0, ax_reg}) + $signed({qx_reg[DELTA_W-1], qx_reg});
        ys     = $signed({2'b0, ay_reg}) + $signed({qy_reg[DELTA_W-1], qy_reg});
        px     = clamp_hi(xs[COORD_W-1:0], cfg.w);
        py     = clamp_hi(ys[COORD_W-1:0], cfg.h);
        span_x = stamp_axis(px, cfg.w);
        span_y = stamp_axis(py, cfg.h);

        {remx_next, qx_next} = dda_step(remx_reg, qx_reg, dx2_reg, two_s_reg);
        {remy_next, qy_next} = dda_step(remy_reg, qy_reg, dy2_reg, two_s_reg);
    end

    assign rect.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                busy_reg <= 1'b1;
            else if (fire && at_last)
                busy_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (rect.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ax_reg    <= pop_cmd.ax;
            ay_reg    <= pop_cmd.ay;
            steps_reg <= pop_cmd.steps;
            dx2_reg   <= $signed({pop_cmd.dx[DELTA_W-1], pop_cmd.dx, 1'b0});
            dy2_reg   <= $signed({pop_cmd.dy[DELTA_W-1], pop_cmd.dy, 1'b0});
            two_s_reg <= $signed({2'b0, pop_cmd.steps, 1'b0});
            remx_reg  <= $signed({3'b0, pop_cmd.steps});
            remy_reg  <= $signed({3'b0, pop_cmd.steps});
            qx_reg    <= '0;
            qy_reg    <= '0;
            i_reg     <= '0;
        end
        else if (fire && !at_last)
        begin
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            i_reg    <= i_reg + 1'b1;
        end
        if (fire)
        begin
            rect.rect_x <= span_x.pos;
            rect.rect_y <= span_y.pos;
            rect.rect_w <= span_x.len;
            rect.rect_h <= span_y.len;
            rect.color  <= cfg.color;
            rect.last   <= at_last;
        end
    end

endmodule

FILE: hdl/brush_stroke_line_stamper.sv
// brush stroke line stamper: pointer events in, clipped brush rectangles out
// holds the config registers; depends on bsls_pkg, bsls_if, bsls_front, bsls_queue, bsls_back
//
// channels: evt takes one event per beat (action, pointer_x, pointer_y in window space);
// rect gives one clipped brush rectangle per beat, last marks the final one of an event;
// cfg writes one register per beat (index, data) and is always ready.
// while enabled, a press inside the canvas gives one beat, a move during a stroke gives
// steps+1 beats with steps = max(|dx|,|dy|) up to 63, other events give none.
// path: an event beat is registered in the front end, its command passes through the queue
// and is loaded into the walker, and each rectangle is registered in the output register.
// throughput: the walker stamps one rectangle per cycle while rect.ready is high, and loads
// each command from the queue only when idle, after the last rectangle of the one before.
// the front end keeps taking events into a 4-entry command queue while lines are walked;
// evt.ready drops only when that queue is full.
// when rect.ready is low with a beat pending, the output register holds it and the walker pauses.
// reset: no stroke, width and height 64, origin 0, pen color 255, enabled.
module brush_stroke_line_stamper
    import bsls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bsls_cfg_if.sink    cfg,
    bsls_event_if.sink  evt,
    bsls_rect_if.source rect
);

    logic [DIM_W-1:0]   canvas_width_reg, canvas_height_reg;
    logic [PTR_W-1:0]   origin_x_reg, origin_y_reg;
    logic [COLOR_W-1:0] pen_color_reg;
    logic               enabled_reg;

    cfg_t cfg_bus;
    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            eff_dim = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            eff_dim = DIM_W'(MAX_DIM);
        else
            eff_dim = v;
    endfunction

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_bus.w       = eff_dim(canvas_width_reg);
        cfg_bus.h       = eff_dim(canvas_height_reg);
        cfg_bus.ox      = origin_x_reg;
        cfg_bus.oy      = origin_y_reg;
        cfg_bus.color   = pen_color_reg;
        cfg_bus.enabled = enabled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= DIM_W'(MAX_DIM);
            canvas_height_reg <= DIM_W'(MAX_DIM);
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            pen_color_reg     <= COLOR_W'(255);
            enabled_reg       <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_CANVAS_WIDTH:  canvas_width_reg  <= cfg.data[DIM_W-1:0];
                REG_CANVAS_HEIGHT: canvas_height_reg <= cfg.data[DIM_W-1:0];
                REG_ORIGIN_X:      origin_x_reg      <= cfg.data[PTR_W-1:0];
                REG_ORIGIN_Y:      origin_y_reg      <= cfg.data[PTR_W-1:0];
                REG_PEN_COLOR:     pen_color_reg     <= cfg.data[COLOR_W-1:0];
                REG_ENABLED:       enabled_reg       <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    bsls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt),
        .cfg        (cfg_bus),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    bsls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    bsls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rect      (rect)
    );

endmodule

FILE: hdl/bsls_checker.sv
// port-level checks on the rectangle channel, bound to the top level
// depends on bsls_pkg and brush_stroke_line_stamper_defines.svh
`include "brush_stroke_line_stamper_defines.svh"

module bsls_checker
    import bsls_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rect_valid,
    input logic               rect_ready,
    input logic [COORD_W-1:0] rect_x,
    input logic [COORD_W-1:0] rect_y,
    input logic [SIZE_W-1:0]  rect_w,
    input logic [SIZE_W-1:0]  rect_h,
    input logic [COLOR_W-1:0] color,
    input logic               last
);

    `BSLS_ASSERT_NEXT(a_rect_hold, rect_valid && !rect_ready, rect_valid, "rect beat dropped")
    `BSLS_ASSERT_NEXT(a_rect_stable, rect_valid && !rect_ready, $stable(rect_x) && $stable(rect_y) && $stable(rect_w) && $stable(rect_h) && $stable(color) && $stable(last), "stalled rect beat changed")
    `BSLS_ASSERT_NOW(a_size_range, rect_valid, rect_w != '0 && rect_h != '0 && rect_w <= SIZE_W'(BRUSH) && rect_h <= SIZE_W'(BRUSH), "brush size out of range")
    `BSLS_ASSERT_NOW(a_on_canvas, rect_valid, ({1'b0, rect_x} + 7'(rect_w)) <= 7'(MAX_DIM) && ({1'b0, rect_y} + 7'(rect_h)) <= 7'(MAX_DIM), "rectangle leaves canvas")

endmodule

bind brush_stroke_line_stamper bsls_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rect_valid (rect.valid),
    .rect_ready (rect.ready),
    .rect_x     (rect.rect_x),
    .rect_y     (rect.rect_y),
    .rect_w     (rect.rect_w),
    .rect_h     (rect.rect_h),
    .color      (rect.color),
    .last       (rect.last)
);

FILE: test/bsls_stroke_checker.sv
`timescale 1ns / 100ps
// checker for the brush stroke line stamper: mirrors config writes, predicts the
// brush rectangles of every accepted event and compares each rect beat in order
// depends on bsls_pkg and bsls_if
module bsls_stroke_checker
    import bsls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bsls_cfg_if    cfg,
    bsls_event_if  evt,
    bsls_rect_if   rect,
    output int     fail_count,
    output int     rects_due,
    output int     rects_seen
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic [COLOR_W-1:0] color;
        logic               last;
    } brush_rect_t;

    brush_rect_t        due_rects[$];
    logic [DIM_W-1:0]   cv_w, cv_h;
    logic [PTR_W-1:0]   org_x, org_y;
    logic [COLOR_W-1:0] pen;
    logic               draw_en;
    logic               stroke_on;
    int                 pen_x, pen_y;
    int                 mismatches, seen;

    function automatic int dim_sat(logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int div_floor(int n, int d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    task automatic stamp_brush(int px, int py, int w, int h, logic fin);
        brush_rect_t r;
        int rx, ry, rw, rh;
        rx = px - BRUSH / 2;
        ry = py - BRUSH / 2;
        rw = BRUSH;
        rh = BRUSH;
        if (rx < 0)
        begin
            rw += rx;
            rx = 0;
        end
        if (ry < 0)
        begin
            rh += ry;
            ry = 0;
        end
        if (rx + rw > w)
            rw = w - rx;
        if (ry + rh > h)
            rh = h - ry;
        r.x     = COORD_W'(rx);
        r.y     = COORD_W'(ry);
        r.w     = SIZE_W'(rw);
        r.h     = SIZE_W'(rh);
        r.color = pen;
        r.last  = fin;
        due_rects.push_back(r);
    endtask

    task automatic walk_event(logic [ACT_W-1:0] act, logic [PTR_W-1:0] px,
                              logic [PTR_W-1:0] py);
        int w, h, lx, ly, dx, dy, steps;
        w  = dim_sat(cv_w);
        h  = dim_sat(cv_h);
        lx = int'(px) - int'(org_x);
        ly = int'(py) - int'(org_y);
        if (!draw_en)
            return;
        case (act)
            ACT_PRESS:
            begin
                if (lx >= 0 && lx < w && ly >= 0 && ly < h)
                begin
                    stroke_on = 1'b1;
                    pen_x = lx;
                    pen_y = ly;
                    stamp_brush(lx, ly, w, h, 1'b1);
                end
            end
            ACT_RELEASE:
                stroke_on = 1'b0;
            ACT_MOVE:
            begin
                if (stroke_on)
                begin
                    lx = clip(lx, 0, w - 1);
                    ly = clip(ly, 0, h - 1);
                    dx = lx - pen_x;
                    dy = ly - pen_y;
                    steps = (dx < 0) ? -dx : dx;
                    if (((dy < 0) ? -dy : dy) > steps)
                        steps = (dy < 0) ? -dy : dy;
                    if (steps == 0)
                        stamp_brush(clip(pen_x, 0, w - 1), clip(pen_y, 0, h - 1), w, h, 1'b1);
                    else
                        for (int i = 0; i <= steps; i++)
                            stamp_brush(
                                clip(pen_x + div_floor(2 * i * dx + steps, 2 * steps), 0, w - 1),
                                clip(pen_y + div_floor(2 * i * dy + steps, 2 * steps), 0, h - 1),
                                w, h, i == steps);
                    pen_x = lx;
                    pen_y = ly;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t rect %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        brush_rect_t want;
        if (!rst_n)
        begin
            due_rects.delete();
            cv_w       = DIM_W'(MAX_DIM);
            cv_h       = DIM_W'(MAX_DIM);
            org_x      = '0;
            org_y      = '0;
            pen        = 32'd255;
            draw_en    = 1'b1;
            stroke_on  = 1'b0;
            pen_x      = 0;
            pen_y      = 0;
            mismatches = 0;
            seen       = 0;
            fail_count <= 0;
            rects_due  <= 0;
            rects_seen <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_CANVAS_WIDTH:  cv_w    = cfg.data[DIM_W-1:0];
                    REG_CANVAS_HEIGHT: cv_h    = cfg.data[DIM_W-1:0];
                    REG_ORIGIN_X:      org_x   = cfg.data[PTR_W-1:0];
                    REG_ORIGIN_Y:      org_y   = cfg.data[PTR_W-1:0];
                    REG_PEN_COLOR:     pen     = cfg.data[COLOR_W-1:0];
                    REG_ENABLED:       draw_en = cfg.data[0];
                    default: ;
                endcase
            end
            if (evt.valid && evt.ready)
                walk_event(evt.action, evt.pointer_x, evt.pointer_y);
            if (rect.valid && rect.ready)
            begin
                seen++;
                if (due_rects.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected rect beat: expected none, actual x=%0d y=%0d w=%0d h=%0d",
                             $time, rect.rect_x, rect.rect_y, rect.rect_w, rect.rect_h);
                end
                else
                begin
                    want = due_rects.pop_front();
                    check_field("x", want.x, rect.rect_x);
                    check_field("y", want.y, rect.rect_y);
                    check_field("w", want.w, rect.rect_w);
                    check_field("h", want.h, rect.rect_h);
                    check_field("color", want.color, rect.color);
                    check_field("last", want.last, rect.last);
                end
            end
            fail_count <= mismatches;
            rects_due  <= due_rects.size();
            rects_seen <= seen;
        end
    end

endmodule

FILE: test/brush_stroke_line_stamper_tb.sv
`timescale 1ns / 100ps
// testbench top for the brush stroke line stamper: drives config writes, directed and
// random pointer events, random rect back-pressure, and gives the verdict
// depends on bsls_pkg, bsls_if, the block and bsls_stroke_checker
module brush_stroke_line_stamper_tb;
    import bsls_pkg::*;

    localparam int SETTLE      = 12;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 33;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bsls_cfg_if   cfg_ch();
    bsls_event_if evt_ch();
    bsls_rect_if  rect_ch();

    int fail_count, rects_due, rects_seen;
    int send_idle_pct, stall_pct;
    int n_events, n_setups;
    int quiet = 0;
    int eff_w, eff_h;
    logic [PTR_W-1:0] cur_ox, cur_oy;

    brush_stroke_line_stamper u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .evt  (evt_ch),
        .rect (rect_ch)
    );

    bsls_stroke_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_ch),
        .evt       (evt_ch),
        .rect      (rect_ch),
        .fail_count(fail_count),
        .rects_due (rects_due),
        .rects_seen(rects_seen)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        rect_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_ch.valid && evt_ch.ready) || (rect_ch.valid && rect_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [PTR_W-1:0] aim(logic [PTR_W-1:0] base, int off);
        return PTR_W'(int'(base) + off);
    endfunction

    task automatic drive_event(logic [ACT_W-1:0] act, logic [PTR_W-1:0] px,
                               logic [PTR_W-1:0] py);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid     <= 1'b1;
        evt_ch.action    <= act;
        evt_ch.pointer_x <= px;
        evt_ch.pointer_y <= py;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        n_events++;
    endtask

    task automatic put_reg(cfg_index_t idx, logic [DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic set_canvas(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                              logic [PTR_W-1:0] ox, logic [PTR_W-1:0] oy,
                              logic [COLOR_W-1:0] color, logic en);
        put_reg(REG_CANVAS_WIDTH, DATA_W'(w));
        put_reg(REG_CANVAS_HEIGHT, DATA_W'(h));
        put_reg(REG_ORIGIN_X, DATA_W'(ox));
        put_reg(REG_ORIGIN_Y, DATA_W'(oy));
        put_reg(REG_PEN_COLOR, color);
        put_reg(REG_ENABLED, DATA_W'(en));
        cfg_ch.valid <= 1'b0;
        eff_w  = (w == 0) ? 1 : ((w > MAX_DIM) ? MAX_DIM : int'(w));
        eff_h  = (h == 0) ? 1 : ((h > MAX_DIM) ? MAX_DIM : int'(h));
        cur_ox = ox;
        cur_oy = oy;
        n_setups++;
    endtask

    // stop sending and wait for every predicted rect plus the block's latency
    task automatic drain();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (rects_due != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return DIM_W'($urandom_range(MAX_DIM + 1, 127));
        return DIM_W'($urandom_range(8, MAX_DIM));
    endfunction

    task automatic random_stroke();
        int lx, ly, moves;
        lx = $urandom_range(0, eff_w - 1);
        ly = $urandom_range(0, eff_h - 1);
        drive_event(ACT_PRESS, aim(cur_ox, lx), aim(cur_oy, ly));
        moves = $urandom_range(1, 6);
        repeat (moves)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                lx += int'($urandom_range(0, 16)) - 8;
                ly += int'($urandom_range(0, 16)) - 8;
            end
            else
            begin
                lx = int'($urandom_range(0, eff_w + 15)) - 8;
                ly = int'($urandom_range(0, eff_h + 15)) - 8;
            end
            drive_event(ACT_MOVE, aim(cur_ox, lx), aim(cur_oy, ly));
        end
        if ($urandom_range(0, 4) != 0)
            drive_event(ACT_RELEASE, aim(cur_ox, lx), aim(cur_oy, ly));
    endtask

    initial
    begin
        int base;
        evt_ch.valid     = 1'b0;
        evt_ch.action    = ACT_PRESS;
        evt_ch.pointer_x = '0;
        evt_ch.pointer_y = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_CANVAS_WIDTH;
        cfg_ch.data      = '0;
        send_idle_pct    = 24;
        stall_pct        = 83;
        n_events         = 0;
        n_setups         = 0;
        eff_w            = MAX_DIM;
        eff_h            = MAX_DIM;
        cur_ox           = '0;
        cur_oy           = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed events on the reset canvas
        drive_event(ACT_PRESS, 12'd0, 12'd0);
        drive_event(ACT_MOVE, 12'd63, 12'd63);
        drive_event(ACT_MOVE, 12'd63, 12'd0);
        drive_event(ACT_MOVE, 12'd63, 12'd0);
        drive_event(ACT_MOVE, 12'd4095, 12'd4095);
        drive_event(ACT_RELEASE, 12'd0, 12'd0);
        drive_event(ACT_MOVE, 12'd10, 12'd10);
        drive_event(ACT_RELEASE, 12'd5, 12'd5);
        drive_event(2'd3, 12'd7, 12'd7);
        drive_event(ACT_PRESS, 12'd64, 12'd10);
        drive_event(ACT_PRESS, 12'd63, 12'd63);
        drive_event(ACT_PRESS, 12'd30, 12'd5);
        drive_event(ACT_MOVE, 12'd0, 12'd40);
        drive_event(ACT_PRESS, 12'd50, 12'd50);
        drain();

        // width saturates to 1, height to 64, canvas shrinks under a live stroke
        set_canvas('0, 7'd127, '0, '0, 32'hFFFF_FFFF, 1'b1);
        drive_event(ACT_MOVE, 12'd5, 12'd5);
        drive_event(ACT_PRESS, 12'd0, 12'd63);
        drive_event(ACT_RELEASE, 12'd0, 12'd0);
        drain();

        set_canvas(7'd20, 7'd10, 12'd4095, 12'd4095, 32'h0, 1'b1);
        drive_event(ACT_PRESS, 12'd4095, 12'd4095);
        drive_event(ACT_PRESS, 12'd4094, 12'd4095);
        drive_event(ACT_MOVE, 12'd0, 12'd0);
        drain();

        set_canvas(7'd20, 7'd10, 12'd4095, 12'd4095, 32'h0, 1'b0);
        drive_event(ACT_PRESS, 12'd4095, 12'd4095);
        drive_event(ACT_RELEASE, 12'd4095, 12'd4095);
        drive_event(ACT_MOVE, 12'd4095, 12'd4095);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 24 : ((ph == 1) ? 83 : 0);
            stall_pct     = (ph == 0) ? 83 : ((ph == 1) ? 24 : 0);
            set_canvas(pick_dim(), pick_dim(), 12'($urandom_range(0, 4000)),
                       12'($urandom_range(0, 4000)), $urandom, 1'b1);
            base = n_events;
            while (n_events - base < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                    random_stroke();
                else
                    drive_event(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                                12'($urandom_range(0, 4095)));
            end
            drain();
        end

        $display("covered %0d pointer events over %0d canvas setups, three idling mixes",
                 n_events, n_setups);
        $display("%0d brush rectangles compared against prediction", rects_seen);
        if (fail_count == 0 && rects_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
